// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted (active low).
`define BSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define BSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bse_pkg;

  // Register indexes on the configuration port
  localparam logic [0:0] CFG_URL_ALPHABET = 1'b0;
  localparam logic [0:0] CFG_PAD_ENABLE   = 1'b1;

  // Padding sign
  localparam logic [6:0] PAD_CHAR = 7'h3D;

  // Group queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One completed or final group, ready to be expanded into characters
  typedef struct packed {
    logic [23:0] bits;      // first byte in the top bits, missing bytes zero
    logic [1:0]  ndata_m1;  // number of alphabet characters minus one
    logic [1:0]  total_m1;  // number of characters incl. padding minus one
    logic        last;      // group closes the message
  } group_t;

  // Map a 6-bit code to its ASCII character
  function automatic logic [6:0] char_of(input logic [5:0] code, input logic url);
    logic [6:0] c7;
    logic [6:0] ch;
    c7 = {1'b0, code};
    if (code < 6'd26) begin
      ch = c7 + 7'd65;
    end else if (code < 6'd52) begin
      ch = c7 + 7'd71;
    end else if (code < 6'd62) begin
      ch = c7 - 7'd4;
    end else if (code == 6'd62) begin
      ch = url ? 7'h2D : 7'h2B;
    end else begin
      ch = url ? 7'h5F : 7'h2F;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/base64_stream_encoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Streaming Base64 encoder.
// Input channel in_*: one message byte per transfer in in_tdata, in_tlast on
// the final byte of a message. Output channel out_*: one ASCII character per
// transfer in out_tdata[6:0] (bit 7 is zero), out_tlast on the final character.
// Config channel cfg_*: index 0 selects the URL-safe alphabet, index 1 enables
// '=' padding; cfg_ready is always high. Write only while the block is idle.
// Each complete 3-byte group gives 4 characters; a final group of 1 or 2 bytes
// gives 2 or 3 characters plus padding up to 4 when enabled.
// Path: a completed group is written into the group queue, and its first
// character then into the output register that drives out_tvalid.
// Throughput: one character per cycle while out_tready is high; the input
// takes 3 bytes per 4 characters. The 2-entry group queue lets bytes arrive
// back to back as the back end drains; in_tready drops only when it is full.
// Receiver stall: the output register holds its character; the queue fills,
// then in_tready falls. Reset (rst_n low, synchronous) empties the queue,
// drops any partial group and restores standard alphabet with padding on.

module base64_stream_encoder_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,   // end_of_message
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [6:0] out_char, [7] zero
  output logic            out_tlast,  // last_char
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [0:0] cfg_data
);

  logic            url_r;
  logic            pad_r;
  logic            f_valid;
  logic            f_ready;
  bse_pkg::group_t f_grp;
  logic            q_valid;
  logic            q_pop;
  bse_pkg::group_t q_grp;
  logic [6:0]      out_char;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      url_r <= 1'b0;
      pad_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bse_pkg::CFG_URL_ALPHABET: url_r <= cfg_data[0];
        bse_pkg::CFG_PAD_ENABLE:   pad_r <= cfg_data[0];
        default:                   ;
      endcase
    end
  end

  bse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_end     (in_tlast),
    .pad_enable (pad_r),
    .grp_valid  (f_valid),
    .grp_ready  (f_ready),
    .grp        (f_grp)
  );

  bse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_grp),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_grp)
  );

  bse_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .grp_valid    (q_valid),
    .grp_pop      (q_pop),
    .grp          (q_grp),
    .url_alphabet (url_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_char     (out_char),
    .out_last     (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

// ===== rtl/bse_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bse_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_end,
  input  wire logic             pad_enable,
  output logic                  grp_valid,
  input  wire logic             grp_ready,
  output bse_pkg::group_t       grp
);

  logic [7:0] pend0_r, pend0_nxt;
  logic [7:0] pend1_r, pend1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;
  logic       complete;

  // Take a byte only when the queue can absorb a group
  assign in_ready = grp_ready;
  assign accept   = in_valid && in_ready;
  assign complete = (cnt_r == 2'd2) || in_end;

  // Build the group entry from pending bytes and the new byte
  always_comb begin
    grp          = '0;
    grp.last     = in_end;
    unique case (cnt_r)
      2'd2: begin
        grp.bits     = {pend0_r, pend1_r, in_byte};
        grp.ndata_m1 = 2'd3;
        grp.total_m1 = 2'd3;
      end
      2'd1: begin
        grp.bits     = {pend0_r, in_byte, 8'h00};
        grp.ndata_m1 = 2'd2;
        grp.total_m1 = pad_enable ? 2'd3 : 2'd2;
      end
      default: begin
        grp.bits     = {in_byte, 16'h0000};
        grp.ndata_m1 = 2'd1;
        grp.total_m1 = pad_enable ? 2'd3 : 2'd1;
      end
    endcase
  end

  assign grp_valid = accept && complete;

  // Hold incomplete bytes, clear the count once a group leaves
  always_comb begin
    pend0_nxt = pend0_r;
    pend1_nxt = pend1_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      if (complete) begin
        cnt_nxt = 2'd0;
      end else begin
        if (cnt_r == 2'd0) begin
          pend0_nxt = in_byte;
        end else begin
          pend1_nxt = in_byte;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 2'd0;
      pend0_r <= 8'h00;
      pend1_r <= 8'h00;
    end else begin
      cnt_r   <= cnt_nxt;
      pend0_r <= pend0_nxt;
      pend1_r <= pend1_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bse_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bse_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire bse_pkg::group_t  wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_pop,
  output bse_pkg::group_t       rd_data
);

  localparam int PtrW = (bse_pkg::QUEUE_DEPTH > 1) ? $clog2(bse_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(bse_pkg::QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(bse_pkg::QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(bse_pkg::QUEUE_DEPTH - 1);

  bse_pkg::group_t       slot_r [bse_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic                  do_wr;
  logic                  do_rd;

  assign wr_ready = (cnt_r != Full);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bse_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bse_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             grp_valid,
  output logic                  grp_pop,
  input  wire bse_pkg::group_t  grp,
  input  wire logic             url_alphabet,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [6:0]            out_char,
  output logic                  out_last
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [6:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic       take;
  logic [5:0] code;

  assign load = !valid_r || out_ready;
  assign take = load && grp_valid;

  // Pick the 6-bit code for the current character position
  always_comb begin
    unique case (idx_r)
      2'd0:    code = grp.bits[23:18];
      2'd1:    code = grp.bits[17:12];
      2'd2:    code = grp.bits[11:6];
      default: code = grp.bits[5:0];
    endcase
  end

  // Expand the head group one character per transfer
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    grp_pop   = 1'b0;
    if (load) begin
      valid_nxt = grp_valid;
    end
    if (take) begin
      char_nxt = (idx_r > grp.ndata_m1) ? bse_pkg::PAD_CHAR
                                        : bse_pkg::char_of(code, url_alphabet);
      last_nxt = grp.last && (idx_r == grp.total_m1);
      if (idx_r == grp.total_m1) begin
        grp_pop = 1'b1;
        idx_nxt = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output payload, no reset
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

// ===== rtl/bse_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bse_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  // Stalled character holds
  property p_out_hold;
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast);
  endproperty

  // Padding that is not final is followed at once by more padding
  property p_pad_run;
    out_tvalid && out_tready && (out_tdata[6:0] == bse_pkg::PAD_CHAR) && !out_tlast
      |=> out_tvalid && (out_tdata[6:0] == bse_pkg::PAD_CHAR);
  endproperty

  `BSE_ASSERT(a_out_hold, clk, rst_n, p_out_hold, "output changed while stalled")

  `BSE_ASSERT(a_pad_run, clk, rst_n, p_pad_run, "padding run broken")

  // Characters are 7-bit ASCII
  `BSE_ASSERT(a_ascii, clk, rst_n, out_tvalid |-> !out_tdata[7], "bit 7 of a character set")

  // Reset empties the output and frees the input
  `BSE_ASSERT_ALWAYS(a_reset, clk, !rst_n |=> !out_tvalid && in_tready, "state after reset")

endmodule

bind base64_stream_encoder_core bse_checker u_bse_checker (.*);

`default_nettype wire

// ===== verif/tb_base64_stream_encoder_core.sv =====
`timescale 1ns / 1ps

module tb_base64_stream_encoder_core;

  // One message byte waiting to be sent
  typedef struct packed {
    logic [7:0] data;
    logic       eom;
  } msg_byte_t;

  // One encoded character expected on the output
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } enc_char_t;

  // Alphabets, first character in the top byte
  localparam logic [8*64-1:0] STD_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [8*64-1:0] URL_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
  localparam int IDLE_PERCENT = 29;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 60;
  localparam int SETTLE_CYCLES = 6;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_index = bse_pkg::CFG_URL_ALPHABET;
  logic [0:0] cfg_data = 1'b0;

  // Stimulus and expectation stores
  msg_byte_t  byte_queue[$];
  enc_char_t  expected_chars[$];
  msg_byte_t  next_byte;

  // Encoder state mirrored by the predictor
  logic       url_sel_q;
  logic       pad_on_q;
  logic [7:0] held_bytes[2];
  logic [1:0] held_count;

  // Flow control knobs shared with the sequencer
  bit         no_idle;
  bit         start_hold;
  int         hold_left;

  int         errors;
  int         bytes_accepted;
  int         messages_sent;
  int         chars_checked;
  int         cfg_writes;

  base64_stream_encoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] data_byte
    .in_tlast   (in_tlast),   // end_of_message
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [6:0] out_char, [7] zero
    .out_tlast  (out_tlast),  // last_char
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Map a 6-bit code to its character under the current alphabet
  function automatic logic [6:0] sextet_ascii(input logic [5:0] code);
    logic [7:0] c;
    if (url_sel_q) begin
      c = URL_ALPHABET[8*(63-code) +: 8];
    end else begin
      c = STD_ALPHABET[8*(63-code) +: 8];
    end
    return c[6:0];
  endfunction

  // Advance the encoder state by one byte and queue the characters it yields
  function automatic void predict_chars(input logic [7:0] b, input logic eom);
    logic [6:0] chars[4];
    logic [7:0] b0;
    logic [7:0] b1;
    int         n;
    enc_char_t  item;
    b0 = held_bytes[0];
    b1 = held_bytes[1];
    n = 0;
    if (held_count == 2'd2) begin
      chars[0] = sextet_ascii(b0[7:2]);
      chars[1] = sextet_ascii({b0[1:0], b1[7:4]});
      chars[2] = sextet_ascii({b1[3:0], b[7:6]});
      chars[3] = sextet_ascii(b[5:0]);
      n = 4;
      held_count = 2'd0;
    end else if (!eom) begin
      held_bytes[held_count] = b;
      held_count = held_count + 2'd1;
    end else if (held_count == 2'd0) begin
      chars[0] = sextet_ascii(b[7:2]);
      chars[1] = sextet_ascii({b[1:0], 4'b0000});
      n = 2;
      if (pad_on_q) begin
        chars[2] = bse_pkg::PAD_CHAR;
        chars[3] = bse_pkg::PAD_CHAR;
        n = 4;
      end
    end else begin
      chars[0] = sextet_ascii(b0[7:2]);
      chars[1] = sextet_ascii({b0[1:0], b[7:4]});
      chars[2] = sextet_ascii({b[3:0], 2'b00});
      n = 3;
      if (pad_on_q) begin
        chars[3] = bse_pkg::PAD_CHAR;
        n = 4;
      end
      held_count = 2'd0;
    end
    for (int i = 0; i < n; i++) begin
      item.ch   = chars[i];
      item.last = eom && (i == n - 1);
      expected_chars = {expected_chars, item};
    end
  endfunction

  // Driver: predict on each accepted byte, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_chars(in_tdata, in_tlast);
        bytes_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (byte_queue.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
          next_byte = byte_queue.pop_front();
          in_tdata  <= next_byte.data;
          in_tlast  <= next_byte.eom;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (start_hold) begin
      start_hold = 1'b0;
      hold_left  = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Monitor: compare each character transfer with the oldest expectation
  always @(posedge clk) begin
    enc_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: out_char=%02h out_tlast=%0b", out_tdata, out_tlast);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (out_tdata !== {1'b0, want.ch}) begin
          $error("out_char mismatch: expected %02h, actual %02h", {1'b0, want.ch}, out_tdata);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last_char mismatch: expected %0b, actual %0b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  task automatic add_byte(input logic [7:0] data, input logic eom);
    msg_byte_t item;
    item.data  = data;
    item.eom   = eom;
    byte_queue = {byte_queue, item};
    if (eom) begin
      messages_sent++;
    end
  endtask

  task automatic add_message(input int len);
    for (int i = 0; i < len; i++) begin
      add_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // Hold until every byte is in and every character out, then let the pipe settle
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (byte_queue.size() != 0 || in_tvalid || expected_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] index, input logic value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    if (index == bse_pkg::CFG_URL_ALPHABET) begin
      url_sel_q = value;
    end else begin
      pad_on_q = value;
    end
  endtask

  task automatic set_config(input logic url, input logic pad);
    write_reg(bse_pkg::CFG_URL_ALPHABET, url);
    write_reg(bse_pkg::CFG_PAD_ENABLE, pad);
  endtask

  // Sequencer: directed messages, then random phases over all settings
  initial begin
    int         count;
    int         len;
    logic [1:0] mode;
    url_sel_q     = 1'b0;
    pad_on_q      = 1'b1;
    held_bytes[0] = 8'h00;
    held_bytes[1] = 8'h00;
    held_count    = 2'd0;
    no_idle       = 1'b0;
    start_hold    = 1'b0;
    hold_left     = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one, two and three byte groups, top codes, zero bytes
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hFB, 1'b0);
    add_byte(8'hEF, 1'b0);
    add_byte(8'hBE, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b1);
    wait_drained();

    // URL alphabet without padding: short final groups stop early
    set_config(1'b1, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h80, 1'b1);
    add_byte(8'hFB, 1'b0);
    add_byte(8'hEF, 1'b0);
    add_byte(8'hBE, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b1);
    wait_drained();

    // Random messages in six phases over all four settings, the third one under back-pressure
    for (int p = 0; p < 6; p++) begin
      mode = 2'(p + 3);
      set_config(mode[0], mode[1]);
      count = 0;
      while (count < PHASE_ITEMS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        add_message(len);
        count += len;
      end
      if (p == 2) begin
        no_idle    = 1'b1;
        start_hold = 1'b1;
      end
      wait_drained();
      no_idle = 1'b0;
    end

    $display("Encoded %0d messages (%0d bytes), checked %0d characters",
             messages_sent, bytes_accepted, chars_checked);
    $display("over %0d register writes covering both alphabets with and without padding",
             cfg_writes);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
